[rtl/dllm_pkg.sv]
`timescale 1ns / 1ps

package dllm_pkg;

    localparam int POOL_NODES = 64;

    // slot index, link (slot or none) and count widths
    localparam int IDX_W  = $clog2(POOL_NODES);
    localparam int LINK_W = $clog2(POOL_NODES + 1);
    localparam int CNT_W  = $clog2(POOL_NODES + 1);

    // fixed payload widths
    localparam int OP_W        = 2;
    localparam int NODE_W      = 6;
    localparam int COUNT_OUT_W = 7;

    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(POOL_NODES);

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_POP    = 2'd2;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [LINK_W-1:0] data;
    } t_wr;

    typedef struct packed {
        logic                   status;
        logic [NODE_W-1:0]      popped;
        logic [COUNT_OUT_W-1:0] count;
    } t_result;

endpackage

[rtl/doubly_linked_list_manager_unit.sv]
`timescale 1ns / 1ps

// Doubly linked list queue over a pool of node slots.
// Input channel (i_valid/o_ready): i_operation selects append at tail,
// delete of slot i_node_index, or pop of the head. Output channel
// (o_valid/i_ready): one result per input transfer with o_status
// (0 done, 1 rejected, list unchanged), o_popped_node (popped slot, else
// zero) and o_list_count (nodes in the list afterwards).
// Sequence: an input transfer reads the prev/next link RAMs at its slot (the
// head slot for pop); the next cycle checks links against head/tail, writes
// up to one entry in each link RAM and registers the result, which moves
// into the output register once the output is free. A new item is accepted
// only once the read then modify/write pass over the link RAMs for the last
// one is done.
// The output has its own register behind the result stage, so a new item is
// accepted while an earlier result waits; a stall of more than one result
// drops o_ready until the output drains.
// Reset (synchronous, active low) empties the list at once: per-entry valid
// flops make every link read as none, so no clearing pass is needed.
module doubly_linked_list_manager_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [dllm_pkg::OP_W-1:0]         i_operation,
    input  logic [dllm_pkg::NODE_W-1:0]       i_node_index,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_status,
    output logic [dllm_pkg::NODE_W-1:0]       o_popped_node,
    output logic [dllm_pkg::COUNT_OUT_W-1:0]  o_list_count
);

    logic                          rd_en;
    logic [dllm_pkg::IDX_W-1:0]    rd_addr;
    logic [dllm_pkg::LINK_W-1:0]   prev_rd, next_rd;
    dllm_pkg::t_wr                 prev_wr, next_wr;
    logic                          res_valid, res_ready;
    dllm_pkg::t_result             res;

    logic                          r_out_valid;
    dllm_pkg::t_result             r_out;

    dllm_ram #(
        .WIDTH (dllm_pkg::LINK_W),
        .DEPTH (dllm_pkg::POOL_NODES)
    ) u_prev_ram (
        .i_clk     (i_clk),
        .i_wr_en   (prev_wr.en),
        .i_wr_addr (prev_wr.addr),
        .i_wr_data (prev_wr.data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (prev_rd)
    );

    dllm_ram #(
        .WIDTH (dllm_pkg::LINK_W),
        .DEPTH (dllm_pkg::POOL_NODES)
    ) u_next_ram (
        .i_clk     (i_clk),
        .i_wr_en   (next_wr.en),
        .i_wr_addr (next_wr.addr),
        .i_wr_data (next_wr.data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (next_rd)
    );

    dllm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_operation  (i_operation),
        .i_node_index (i_node_index),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_prev_rd    (prev_rd),
        .i_next_rd    (next_rd),
        .o_prev_wr    (prev_wr),
        .o_next_wr    (next_wr),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    assign res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out.status;
    assign o_popped_node = r_out.popped;
    assign o_list_count  = r_out.count;

endmodule

[rtl/dllm_ram.sv]
`timescale 1ns / 1ps

module dllm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/dllm_ctrl.sv]
`timescale 1ns / 1ps

module dllm_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [dllm_pkg::OP_W-1:0]         i_operation,
    input  logic [dllm_pkg::NODE_W-1:0]       i_node_index,
    output logic                              o_rd_en,
    output logic [dllm_pkg::IDX_W-1:0]        o_rd_addr,
    input  logic [dllm_pkg::LINK_W-1:0]       i_prev_rd,
    input  logic [dllm_pkg::LINK_W-1:0]       i_next_rd,
    output dllm_pkg::t_wr                     o_prev_wr,
    output dllm_pkg::t_wr                     o_next_wr,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output dllm_pkg::t_result                 o_res
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                                 r_state, n_state;
    logic [dllm_pkg::LINK_W-1:0]          r_head, n_head;
    logic [dllm_pkg::LINK_W-1:0]          r_tail, n_tail;
    logic [dllm_pkg::CNT_W-1:0]           r_count, n_count;
    logic [dllm_pkg::POOL_NODES-1:0]      r_prev_vld, n_prev_vld;
    logic [dllm_pkg::POOL_NODES-1:0]      r_next_vld, n_next_vld;
    logic [dllm_pkg::OP_W-1:0]            r_op;
    logic [dllm_pkg::NODE_W-1:0]          r_idx;
    logic [dllm_pkg::IDX_W-1:0]           r_addr;
    logic                                 r_pv, r_nv;
    logic                                 r_res_valid, n_res_valid;
    dllm_pkg::t_result                    r_res, n_res;

    logic                                 accept;
    logic                                 in_ok;
    logic [dllm_pkg::LINK_W-1:0]          in_link;
    logic                                 v_ok;
    logic [dllm_pkg::LINK_W-1:0]          v_link;
    logic [dllm_pkg::LINK_W-1:0]          p, n;
    logic                                 p_ok, n_ok;
    logic                                 ok;
    logic                                 clr;
    dllm_pkg::t_wr                        prev_wr, next_wr;

    assign o_ready = (r_state == S_IDLE) && (!r_res_valid || i_res_ready);
    assign accept  = i_valid && o_ready;

    assign in_ok   = int'(i_node_index) < dllm_pkg::POOL_NODES;
    assign in_link = dllm_pkg::LINK_W'(i_node_index);

    // pop reads the head entry, append/delete read the given slot
    assign o_rd_en   = accept;
    assign o_rd_addr = (i_operation == dllm_pkg::OP_POP) ? r_head[dllm_pkg::IDX_W-1:0]
                                                         : in_link[dllm_pkg::IDX_W-1:0];

    assign v_ok   = int'(r_idx) < dllm_pkg::POOL_NODES;
    assign v_link = dllm_pkg::LINK_W'(r_idx);

    // entries never written since reset or cleared read as none
    assign p    = r_pv ? i_prev_rd : dllm_pkg::LINK_NONE;
    assign n    = r_nv ? i_next_rd : dllm_pkg::LINK_NONE;
    assign p_ok = (p != dllm_pkg::LINK_NONE);
    assign n_ok = (n != dllm_pkg::LINK_NONE);

    always_comb begin
        ok      = 1'b0;
        clr     = 1'b0;
        prev_wr = '0;
        next_wr = '0;
        n_head  = r_head;
        n_tail  = r_tail;
        case (r_op)
            dllm_pkg::OP_APPEND: begin
                if (v_ok && !p_ok && !n_ok && (r_head != v_link) && (r_tail != v_link)) begin
                    ok = 1'b1;
                    if (r_tail == dllm_pkg::LINK_NONE) begin
                        n_head = v_link;
                    end else begin
                        prev_wr = '{en: 1'b1, addr: r_addr, data: r_tail};
                        next_wr = '{en: 1'b1, addr: r_tail[dllm_pkg::IDX_W-1:0],
                                    data: v_link};
                    end
                    n_tail = v_link;
                end
            end
            dllm_pkg::OP_DELETE: begin
                if (v_ok && (r_count != '0)) begin
                    if (!p_ok && !n_ok) begin
                        if ((r_head == v_link) && (r_tail == v_link)) begin
                            ok     = 1'b1;
                            n_head = dllm_pkg::LINK_NONE;
                            n_tail = dllm_pkg::LINK_NONE;
                        end
                    end else if (!n_ok) begin
                        if (r_tail == v_link) begin
                            ok      = 1'b1;
                            n_tail  = p;
                            next_wr = '{en: 1'b1, addr: p[dllm_pkg::IDX_W-1:0],
                                        data: dllm_pkg::LINK_NONE};
                        end
                    end else if (!p_ok) begin
                        if (r_head == v_link) begin
                            ok      = 1'b1;
                            n_head  = n;
                            prev_wr = '{en: 1'b1, addr: n[dllm_pkg::IDX_W-1:0],
                                        data: dllm_pkg::LINK_NONE};
                        end
                    end else begin
                        ok      = 1'b1;
                        prev_wr = '{en: 1'b1, addr: n[dllm_pkg::IDX_W-1:0], data: p};
                        next_wr = '{en: 1'b1, addr: p[dllm_pkg::IDX_W-1:0], data: n};
                    end
                    clr = ok;
                end
            end
            dllm_pkg::OP_POP: begin
                if ((r_count != '0) && (r_head != dllm_pkg::LINK_NONE)) begin
                    ok  = 1'b1;
                    clr = 1'b1;
                    if (n_ok) begin
                        n_head  = n;
                        prev_wr = '{en: 1'b1, addr: n[dllm_pkg::IDX_W-1:0],
                                    data: dllm_pkg::LINK_NONE};
                    end else begin
                        n_head = dllm_pkg::LINK_NONE;
                        n_tail = dllm_pkg::LINK_NONE;
                    end
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_prev_vld  = r_prev_vld;
        n_next_vld  = r_next_vld;
        n_res_valid = r_res_valid && !i_res_ready;
        n_res       = r_res;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                if (ok && (r_op == dllm_pkg::OP_APPEND)) begin
                    n_count = r_count + dllm_pkg::CNT_W'(1);
                end else if (ok) begin
                    n_count = r_count - dllm_pkg::CNT_W'(1);
                end
                if (prev_wr.en) begin
                    n_prev_vld[prev_wr.addr] = 1'b1;
                end
                if (next_wr.en) begin
                    n_next_vld[next_wr.addr] = 1'b1;
                end
                // the removed slot's own links go to none last
                if (clr) begin
                    n_prev_vld[r_addr] = 1'b0;
                    n_next_vld[r_addr] = 1'b0;
                end
                n_res_valid  = 1'b1;
                n_res.status = !ok;
                n_res.popped = (ok && (r_op == dllm_pkg::OP_POP))
                             ? dllm_pkg::NODE_W'(r_head) : '0;
                n_res.count  = dllm_pkg::COUNT_OUT_W'(n_count);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= dllm_pkg::LINK_NONE;
            r_tail      <= dllm_pkg::LINK_NONE;
            r_count     <= '0;
            r_prev_vld  <= '0;
            r_next_vld  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_prev_vld  <= n_prev_vld;
            r_next_vld  <= n_next_vld;
            r_res_valid <= n_res_valid;
            if (r_state == S_EXEC) begin
                r_head <= n_head;
                r_tail <= n_tail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (accept) begin
            r_op   <= i_operation;
            r_idx  <= i_node_index;
            r_addr <= o_rd_addr;
            r_pv   <= r_prev_vld[o_rd_addr] && (in_ok || (i_operation == dllm_pkg::OP_POP));
            r_nv   <= r_next_vld[o_rd_addr] && (in_ok || (i_operation == dllm_pkg::OP_POP));
        end
    end

    // link writes only in the modify cycle
    assign o_prev_wr   = (r_state == S_EXEC) ? prev_wr : '0;
    assign o_next_wr   = (r_state == S_EXEC) ? next_wr : '0;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dllm_pkg::CNT_W'(dllm_pkg::POOL_NODES))
        else $error("node count above pool size");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_head == dllm_pkg::LINK_NONE))
        else $error("head and count disagree on empty list");

    a_empty_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == dllm_pkg::LINK_NONE) == (r_tail == dllm_pkg::LINK_NONE))
        else $error("head and tail disagree on empty list");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == dllm_pkg::CNT_W'(1)) |-> (r_head == r_tail))
        else $error("single node list with head not equal to tail");

    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 r_res_valid)
        else $error("accepted transfer produced no result");

endmodule
